// ----- sv/pidtf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID controller package
// Register indexes, field widths and saturation helpers shared by the
// filtered-derivative PID controller.
// ----------------------------------------------------------------------------
package pidtf_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [2:0] REG_DERIV_POLE = 3'd3;
	localparam logic [2:0] REG_INTEG_MIN  = 3'd4;
	localparam logic [2:0] REG_INTEG_MAX  = 3'd5;

	// Request kinds carried on the input tuser.
	localparam logic REQ_STEP  = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	// Field widths.
	localparam int SAMPLE_W = 16;
	localparam int ERR_W    = SAMPLE_W + 1;
	localparam int Q_W      = 32;
	localparam int POLE_W   = 18;
	localparam int WIDE_W   = 52;

	// Q16.16 rounding constant for the pole product (one half LSB).
	localparam logic signed [49:0] Q_ONE_HALF = 50'sd32768;

	localparam logic signed [WIDE_W-1:0] Q_MAX_W = WIDE_W'(64'sd2147483647);
	localparam logic signed [WIDE_W-1:0] Q_MIN_W = WIDE_W'(-64'sd2147483648);

	// Saturate a wide signed value to the signed 32-bit range.
	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > Q_MAX_W) begin
			r = Q_MAX_W[Q_W-1:0];
		end else if (v < Q_MIN_W) begin
			r = Q_MIN_W[Q_W-1:0];
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

endpackage : pidtf_pkg
`default_nettype wire

// ----- sv/pid_tustin_filtered_derivative.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID controller with trapezoidal integrator and filtered derivative
// One control step per beat: error, clamped integrator, first-order
// filtered derivative and a saturated Q16.16 sum of the three terms.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  s_*       in         tuser = req_type, tdata = target, measured
//  m_*       out        tdata = control_out, tuser = integ_free
//  cfg_*     in         register index and 32-bit write data
//
// Three register stages: input register, state update, result register.
// One beat is accepted per cycle unless m_tready stalls the pipeline;
// the integrator and derivative updates close within the single
// state-update stage.
// Reset clears the state, the pipeline valids and loads register defaults.
// Stalls on m_tready hold each stage; empty stages keep accepting beats.
//
module pid_tustin_filtered_derivative
	import pidtf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [15:0] target, [31:16] measured
	input  wire logic        s_tuser,   // [0] req_type
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] control_out
	output logic             m_tuser,   // [0] integ_free
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata
);

	// Configuration registers.
	logic signed [Q_W-1:0]    prop_gain_q;
	logic signed [Q_W-1:0]    integ_gain_q;
	logic signed [Q_W-1:0]    deriv_gain_q;
	logic signed [POLE_W-1:0] deriv_pole_q;
	logic signed [Q_W-1:0]    integ_min_q;
	logic signed [Q_W-1:0]    integ_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= '0;
			integ_gain_q <= '0;
			deriv_gain_q <= '0;
			deriv_pole_q <= '0;
			integ_min_q  <= 32'sh8000_0000;
			integ_max_q  <= 32'sh7fff_ffff;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN:  prop_gain_q  <= cfg_wdata;
				REG_INTEG_GAIN: integ_gain_q <= cfg_wdata;
				REG_DERIV_GAIN: deriv_gain_q <= cfg_wdata;
				REG_DERIV_POLE: deriv_pole_q <= cfg_wdata[POLE_W-1:0];
				REG_INTEG_MIN:  integ_min_q  <= cfg_wdata;
				REG_INTEG_MAX:  integ_max_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Pipeline flow control.
	logic valid_s1;
	logic valid_s2;
	logic m_tvalid_q;
	logic out_open;
	logic s2_open;
	logic adv1;
	logic adv2;

	assign out_open = !m_tvalid_q || m_tready;
	assign s2_open  = !valid_s2 || out_open;
	assign adv2     = valid_s2 && out_open;
	assign adv1     = valid_s1 && s2_open;
	assign s_tready = !valid_s1 || s2_open;

	// Input register.
	logic                       clear_s1;
	logic signed [SAMPLE_W-1:0] target_s1;
	logic signed [SAMPLE_W-1:0] measured_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			clear_s1    <= (s_tuser == REQ_CLEAR);
			target_s1   <= s_tdata[15:0];
			measured_s1 <= s_tdata[31:16];
		end
	end

	// Controller state, updated as an item leaves the input register.
	logic signed [ERR_W-1:0] prev_error_q;
	logic signed [Q_W-1:0]   integ_acc_q;
	logic signed [Q_W-1:0]   deriv_acc_q;

	// Error and its trapezoidal sum and difference.
	logic signed [ERR_W-1:0] err;
	logic signed [ERR_W:0]   err_sum;
	logic signed [ERR_W:0]   err_diff;

	assign err      = ERR_W'(target_s1) - ERR_W'(measured_s1);
	assign err_sum  = (ERR_W+1)'(err) + (ERR_W+1)'(prev_error_q);
	assign err_diff = (ERR_W+1)'(err) - (ERR_W+1)'(prev_error_q);

	// Integrator: accumulate, then clamp low first and high second.
	logic signed [49:0]     integ_prod;
	logic signed [50:0]     integ_sum;
	logic signed [Q_W-1:0]  integ_next;
	logic                   integ_free;

	assign integ_prod = integ_gain_q * err_sum;
	assign integ_sum  = 51'(integ_acc_q) + 51'(integ_prod);

	always_comb begin
		priority if (integ_sum < 51'(integ_min_q)) begin
			integ_next = integ_min_q;
		end else if (integ_sum > 51'(integ_max_q)) begin
			integ_next = integ_max_q;
		end else begin
			integ_next = integ_sum[Q_W-1:0];
		end
	end

	assign integ_free = !((integ_next == integ_min_q) || (integ_next == integ_max_q));

	// Filtered derivative: rounded pole product plus the gain term.
	logic signed [49:0]      pole_prod;
	logic signed [49:0]      pole_rnd;
	logic signed [33:0]      pole_term;
	logic signed [49:0]      deriv_prod;
	logic signed [WIDE_W-1:0] deriv_sum;
	logic signed [Q_W-1:0]   deriv_next;

	assign pole_prod  = deriv_pole_q * deriv_acc_q;
	assign pole_rnd   = pole_prod + Q_ONE_HALF;
	assign pole_term  = pole_rnd[49:16];
	assign deriv_prod = deriv_gain_q * err_diff;
	assign deriv_sum  = WIDE_W'(pole_term) + WIDE_W'(deriv_prod);
	assign deriv_next = sat_q(deriv_sum);

	// Proportional term.
	logic signed [48:0] prop_prod;

	assign prop_prod = prop_gain_q * err;

	// State update and second-stage register.
	logic signed [48:0] prop_s2;
	logic               free_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			prev_error_q <= '0;
			integ_acc_q  <= '0;
			deriv_acc_q  <= '0;
		end else begin
			if (s2_open) begin
				valid_s2 <= valid_s1;
			end
			if (adv1) begin
				if (clear_s1) begin
					prev_error_q <= '0;
					integ_acc_q  <= '0;
					deriv_acc_q  <= '0;
				end else begin
					prev_error_q <= err;
					integ_acc_q  <= integ_next;
					deriv_acc_q  <= deriv_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			prop_s2 <= clear_s1 ? '0 : prop_prod;
			free_s2 <= clear_s1 ? 1'b1 : integ_free;
		end
	end

	// Output sum; the state registers hold the values of the item in stage two.
	logic signed [WIDE_W-1:0] out_sum;
	logic [31:0]              control_q;
	logic                     free_q;

	assign out_sum = WIDE_W'(prop_s2) + WIDE_W'(integ_acc_q) + WIDE_W'(deriv_acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_open) begin
			m_tvalid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			control_q <= sat_q(out_sum);
			free_q    <= free_s2;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = control_q;
	assign m_tuser  = free_q;

endmodule : pid_tustin_filtered_derivative
`default_nettype wire
